/* hdl/id_bmp_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// id_bmp_pkg: shared types and codes for the identifier bitmap
// Request and response items, operation codes and sequencer states.
// ---------------------------------------------------------------------------
package id_bmp_pkg;

   localparam int IDENT_W = 16;

   // Operation codes carried in the request item
   localparam logic [1:0] FUNC_ADD    = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_GET    = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic [IDENT_W-1:0] ident;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [IDENT_W-1:0] lowest_ident;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOCATE,
      ST_MOD_RD,
      ST_MOD_WR,
      ST_SCAN,
      ST_GET_DONE
   } state_type;

endpackage
`default_nettype wire

/* hdl/id_bitmap_set_find_first.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// id_bitmap_set_find_first: identifier membership bitmap with find-first-set
// Add and remove set or clear one identifier's bit; get scans the bitmap
// words from the lowest and returns the lowest identifier present.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  id_bmp_pkg::req_type (func, ident)
//   rsp      out        rsp_valid / rsp_ready  id_bmp_pkg::rsp_type (found, lowest_ident)
//
// After reset a clearing pass writes zero to every word, one word a cycle:
// NUM_IDS / WORD_BITS words (8192 by default), with req_ready low.
// Add and remove run a reciprocal multiply for the word index, a
// remainder step and a read-modify-write of the word memory.
// Get reads one word a cycle, pipelined behind the registered memory read,
// and stops at the first nonzero word or after the last word.
// An item is accepted while a response still waits; a get that finishes
// holds until the response register is free.
// ---------------------------------------------------------------------------
module id_bitmap_set_find_first #(
   parameter int NUM_IDS   = 65536,
   parameter int WORD_BITS = 8
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire id_bmp_pkg::req_type  req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output id_bmp_pkg::rsp_type       rsp_data
);

   localparam int ID_W      = id_bmp_pkg::IDENT_W;
   localparam int NUM_WORDS = NUM_IDS / WORD_BITS;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   // floor(ident / WORD_BITS) = (ident * RECIP) >> SHIFT, exact for ID_W-bit ident
   localparam int SHIFT     = ID_W + BIT_W;
   localparam int RECIP     = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
   localparam int RECIP_W   = ID_W + 1;
   localparam int PROD_W    = ID_W + RECIP_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);

   id_bmp_pkg::state_type state_ff, state_in;

   logic [1:0]           func_ff, func_in;
   logic [ID_W-1:0]      ident_ff, ident_in;
   logic [ID_W-1:0]      quot_ff, quot_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic                 issue_done_ff, issue_done_in;
   logic [ID_W-1:0]      base_ff, base_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic                 chk_last_ff, chk_last_in;
   logic [ID_W-1:0]      chk_base_ff, chk_base_in;
   logic                 res_found_ff, res_found_in;
   logic [ID_W-1:0]      res_ident_ff, res_ident_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   id_bmp_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [WORD_BITS-1:0] rdata_ff;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wdata;
   logic                 we;

   logic                 req_fire;
   logic                 rsp_free;
   logic [PROD_W-1:0]    prod;
   logic [ID_W-1:0]      rem_full;
   logic                 in_range;
   logic [AW-1:0]        quot_addr;
   logic [WORD_BITS-1:0] bit_mask;
   logic [WORD_BITS-1:0] lowest_one;
   logic [BIT_W-1:0]     lowest_idx;
   logic                 hit;

   assign req_ready = (state_ff == id_bmp_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Shared arithmetic: word index, bit index and the lowest set bit of a word
   always_comb begin
      prod       = PROD_W'(ident_ff) * PROD_W'(RECIP);
      rem_full   = ident_ff - ID_W'(32'(quot_ff) * 32'(WORD_BITS));
      in_range   = 32'(quot_ff) < 32'(NUM_WORDS);
      quot_addr  = AW'(quot_ff);
      bit_mask   = WORD_BITS'(1) << bit_ff;
      lowest_one = rdata_ff & (~rdata_ff + WORD_BITS'(1));
      lowest_idx = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (lowest_one[j]) begin
            lowest_idx = lowest_idx | BIT_W'(j);
         end
      end
      hit = chk_vld_ff && (rdata_ff != '0);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         id_bmp_pkg::ST_CLEAR: begin
            if (addr_ff == LAST_ADDR) begin
               state_in = id_bmp_pkg::ST_IDLE;
            end
         end
         id_bmp_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.func)
                  id_bmp_pkg::FUNC_ADD,
                  id_bmp_pkg::FUNC_REMOVE: state_in = id_bmp_pkg::ST_LOCATE;
                  id_bmp_pkg::FUNC_GET:    state_in = id_bmp_pkg::ST_SCAN;
                  default:                 state_in = id_bmp_pkg::ST_IDLE;
               endcase
            end
         end
         id_bmp_pkg::ST_LOCATE: state_in = id_bmp_pkg::ST_MOD_RD;
         id_bmp_pkg::ST_MOD_RD: begin
            state_in = in_range ? id_bmp_pkg::ST_MOD_WR : id_bmp_pkg::ST_IDLE;
         end
         id_bmp_pkg::ST_MOD_WR: state_in = id_bmp_pkg::ST_IDLE;
         id_bmp_pkg::ST_SCAN: begin
            if (hit || (chk_vld_ff && chk_last_ff)) begin
               state_in = id_bmp_pkg::ST_GET_DONE;
            end
         end
         id_bmp_pkg::ST_GET_DONE: begin
            if (rsp_free) begin
               state_in = id_bmp_pkg::ST_IDLE;
            end
         end
         default: state_in = id_bmp_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      func_in       = func_ff;
      ident_in      = ident_ff;
      quot_in       = quot_ff;
      bit_in        = bit_ff;
      addr_in       = addr_ff;
      issue_done_in = issue_done_ff;
      base_in       = base_ff;
      chk_vld_in    = 1'b0;
      chk_last_in   = chk_last_ff;
      chk_base_in   = chk_base_ff;
      res_found_in  = res_found_ff;
      res_ident_in  = res_ident_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rd_addr       = quot_addr;
      wr_addr       = quot_addr;
      wdata         = '0;
      we            = 1'b0;

      unique case (state_ff)
         id_bmp_pkg::ST_CLEAR: begin
            wr_addr = addr_ff;
            we      = 1'b1;
            addr_in = addr_ff + AW'(1);
         end
         id_bmp_pkg::ST_IDLE: begin
            if (req_fire) begin
               func_in       = req_data.func;
               ident_in      = req_data.ident;
               addr_in       = '0;
               base_in       = '0;
               issue_done_in = 1'b0;
            end
         end
         id_bmp_pkg::ST_LOCATE: begin
            quot_in = ID_W'(prod >> SHIFT);
         end
         id_bmp_pkg::ST_MOD_RD: begin
            bit_in = BIT_W'(rem_full);
         end
         id_bmp_pkg::ST_MOD_WR: begin
            we    = 1'b1;
            wdata = (func_ff == id_bmp_pkg::FUNC_ADD) ? (rdata_ff | bit_mask)
                                                      : (rdata_ff & ~bit_mask);
         end
         id_bmp_pkg::ST_SCAN: begin
            // Issue one read a cycle; check the word read on the previous cycle
            rd_addr = addr_ff;
            if (!issue_done_ff) begin
               chk_vld_in    = 1'b1;
               chk_last_in   = (addr_ff == LAST_ADDR);
               chk_base_in   = base_ff;
               issue_done_in = (addr_ff == LAST_ADDR);
               addr_in       = addr_ff + AW'(1);
               base_in       = base_ff + ID_W'(WORD_BITS);
            end
            if (hit) begin
               res_found_in = 1'b1;
               res_ident_in = chk_base_ff + ID_W'(lowest_idx);
            end else begin
               res_found_in = 1'b0;
               res_ident_in = '0;
            end
         end
         id_bmp_pkg::ST_GET_DONE: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.found        = res_found_ff;
               rsp_data_in.lowest_ident = res_ident_ff;
            end
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= id_bmp_pkg::ST_CLEAR;
         addr_ff       <= '0;
         issue_done_ff <= 1'b0;
         chk_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         issue_done_ff <= issue_done_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      ident_ff     <= ident_in;
      quot_ff      <= quot_in;
      bit_ff       <= bit_in;
      base_ff      <= base_in;
      chk_last_ff  <= chk_last_in;
      chk_base_ff  <= chk_base_in;
      res_found_ff <= res_found_in;
      res_ident_ff <= res_ident_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Bitmap word memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wdata;
      end
      rdata_ff <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* verif/id_bitmap_set_find_first_tb.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// id_bitmap_set_find_first_tb: self-checking bench for the identifier bitmap
// A directed table covers reset, the extreme identifiers, repeats and the
// unused selector. Random add, remove, get and unused items follow in three
// idling phases. Gets are checked against the table or a local bitmap mirror.
// ---------------------------------------------------------------------------
module id_bitmap_set_find_first_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int ID_COUNT       = 65536;
   localparam int RAND_PER_PHASE = 25;
   localparam int SETTLE_CYCLES  = 20;

   typedef struct {
      id_bmp_pkg::req_type item;
      bit                  typed;
      id_bmp_pkg::rsp_type want;
   } dir_row_type;

   localparam id_bmp_pkg::rsp_type NO_ANSWER = '0;
   localparam id_bmp_pkg::rsp_type EMPTY_SET = '{found: 1'b0, lowest_ident: 16'd0};

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   id_bmp_pkg::req_type req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   id_bmp_pkg::rsp_type rsp_data;

   bit                  id_present [ID_COUNT];
   id_bmp_pkg::rsp_type pending_lowest [$];
   int                  err_count;
   int                  send_idle_pct;
   int                  recv_idle_pct;

   dir_row_type dir_table [25] = '{
      '{'{id_bmp_pkg::FUNC_GET,    16'd0},     1'b1, EMPTY_SET},
      '{'{id_bmp_pkg::FUNC_GET,    16'd65535}, 1'b1, EMPTY_SET},
      '{'{id_bmp_pkg::FUNC_ADD,    16'd65535}, 1'b0, NO_ANSWER},
      '{'{id_bmp_pkg::FUNC_GET,    16'd0},     1'b1, '{1'b1, 16'd65535}},
      '{'{id_bmp_pkg::FUNC_ADD,    16'd0},     1'b0, NO_ANSWER},
      '{'{id_bmp_pkg::FUNC_GET,    16'd0},     1'b1, '{1'b1, 16'd0}},
      '{'{id_bmp_pkg::FUNC_ADD,    16'd0},     1'b0, NO_ANSWER},
      '{'{id_bmp_pkg::FUNC_REMOVE, 16'd0},     1'b0, NO_ANSWER},
      '{'{id_bmp_pkg::FUNC_GET,    16'd0},     1'b1, '{1'b1, 16'd65535}},
      '{'{id_bmp_pkg::FUNC_REMOVE, 16'd0},     1'b0, NO_ANSWER},
      '{'{id_bmp_pkg::FUNC_GET,    16'd0},     1'b1, '{1'b1, 16'd65535}},
      '{'{FUNC_UNUSED,             16'd5},     1'b0, NO_ANSWER},
      '{'{id_bmp_pkg::FUNC_GET,    16'd0},     1'b1, '{1'b1, 16'd65535}},
      '{'{id_bmp_pkg::FUNC_ADD,    16'd7},     1'b0, NO_ANSWER},
      '{'{id_bmp_pkg::FUNC_ADD,    16'd8},     1'b0, NO_ANSWER},
      '{'{id_bmp_pkg::FUNC_GET,    16'd0},     1'b1, '{1'b1, 16'd7}},
      '{'{id_bmp_pkg::FUNC_REMOVE, 16'd7},     1'b0, NO_ANSWER},
      '{'{id_bmp_pkg::FUNC_GET,    16'd0},     1'b1, '{1'b1, 16'd8}},
      '{'{id_bmp_pkg::FUNC_REMOVE, 16'd65535}, 1'b0, NO_ANSWER},
      '{'{id_bmp_pkg::FUNC_REMOVE, 16'd8},     1'b0, NO_ANSWER},
      '{'{id_bmp_pkg::FUNC_GET,    16'd0},     1'b1, EMPTY_SET},
      '{'{id_bmp_pkg::FUNC_ADD,    16'd43690}, 1'b0, NO_ANSWER},
      '{'{id_bmp_pkg::FUNC_ADD,    16'd21845}, 1'b0, NO_ANSWER},
      '{'{id_bmp_pkg::FUNC_GET,    16'd43690}, 1'b0, NO_ANSWER},
      '{'{FUNC_UNUSED,             16'd65535}, 1'b0, NO_ANSWER}
   };

   id_bitmap_set_find_first DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Lowest identifier present in the mirror, or the empty answer
   function automatic id_bmp_pkg::rsp_type predict_lowest();
      id_bmp_pkg::rsp_type r;
      r = '0;
      for (int i = 0; i < ID_COUNT; i++) begin
         if (id_present[i]) begin
            r.found        = 1'b1;
            r.lowest_ident = i[15:0];
            return r;
         end
      end
      return r;
   endfunction

   task automatic track_item(input id_bmp_pkg::req_type item, input bit typed,
                             input id_bmp_pkg::rsp_type want);
      case (item.func)
         id_bmp_pkg::FUNC_ADD:    id_present[item.ident] = 1'b1;
         id_bmp_pkg::FUNC_REMOVE: id_present[item.ident] = 1'b0;
         id_bmp_pkg::FUNC_GET:    pending_lowest.push_back(typed ? want : predict_lowest());
         default:                 ;
      endcase
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic drive_item(input id_bmp_pkg::req_type item, input bit typed,
                             input id_bmp_pkg::rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      track_item(item, typed, want);
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_lowest.size() != 0) @(negedge clock);
   endtask

   function automatic logic [15:0] random_ident();
      if ($urandom_range(3) == 0) return 16'($urandom_range(65535));
      return 16'($urandom_range(255));
   endfunction

   // Mostly adds and gets; removes often hit the current lowest member
   function automatic id_bmp_pkg::req_type random_item();
      id_bmp_pkg::req_type item;
      id_bmp_pkg::rsp_type low;
      int                  pick;
      pick       = $urandom_range(99);
      item.ident = random_ident();
      if (pick < 40) begin
         item.func = id_bmp_pkg::FUNC_ADD;
      end else if (pick < 65) begin
         item.func = id_bmp_pkg::FUNC_REMOVE;
         low = predict_lowest();
         if (low.found && $urandom_range(1) == 0) item.ident = low.lowest_ident;
      end else if (pick < 95) begin
         item.func = id_bmp_pkg::FUNC_GET;
      end else begin
         item.func = FUNC_UNUSED;
      end
      return item;
   endfunction

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      id_bmp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lowest.size() == 0) begin
            $error("unexpected result item: found %0d lowest_ident %0d",
                   rsp_data.found, rsp_data.lowest_ident);
            err_count++;
         end else begin
            want = pending_lowest.pop_front();
            if (rsp_data.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_data.found);
               err_count++;
            end
            if (rsp_data.lowest_ident !== want.lowest_ident) begin
               $error("lowest_ident: expected %0d, got %0d",
                      want.lowest_ident, rsp_data.lowest_ident);
               err_count++;
            end
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      err_count     = 0;
      send_idle_pct = 36;
      recv_idle_pct = 63;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         drive_item(dir_table[i].item, dir_table[i].typed, dir_table[i].want);
      end

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 63;
            recv_idle_pct = 36;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         hold_until_drained();
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            if ($urandom_range(15) == 0) hold_until_drained();
            drive_item(random_item(), 1'b0, NO_ANSWER);
         end
      end

      req_valid <= 1'b0;
      while (pending_lowest.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (err_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Allow for the clearing pass and every get scanning the whole map
   initial begin
      #50_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
`default_nettype wire
